/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DATA_W  = 32;
	localparam int MODE_W  = 3;
	localparam int COUNT_W = 5;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DROP_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DROP_BACK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] value;
	} bdq_in_t;

	typedef struct packed {
		logic               ok;
		logic               found;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} bdq_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} bdq_state_t;

endpackage

/* rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [bdq_pkg::DATA_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [bdq_pkg::DATA_W-1:0] rdata
);
	import bdq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Ring-buffer deque of signed 32-bit values with push/drop at both ends
// and a linear search.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid/in_ready with in_data (mode, value); a transfer
//   takes one operation. out channel: out_valid/out_ready with out_data
//   (ok, found, count, is_empty); one result per operation, in order.
//   pushes and drops: executed in ST_EXEC, result loaded from ST_DONE.
//   search: entries are read one per cycle from the front through the
//   single ram read port and one comparator; the result is loaded from
//   ST_DONE once the scan ends, which is early on a hit.
//   one operation is in flight at a time; in_ready is high only while the
//   sequencer is idle, and a new operation may be taken while the previous
//   result still sits in the output register.
//   a stalled receiver holds the result in the output register; the next
//   operation completes but waits for the register to drain.
//   reset empties the deque (head and count cleared); stored values are
//   not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bdq_pkg::bdq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bdq_pkg::bdq_out_t out_data
);
	import bdq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	bdq_state_t state_q, state_d;

	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] value_q;
	logic [IW-1:0]     head_q, head_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     scan_q;
	logic              hit_q;
	logic              ok_q;
	logic              rd_vld_s1;
	logic              out_valid_q;
	bdq_out_t          res_q;

	logic              accept;
	logic              full;
	logic              empty;
	logic [CW-1:0]     offset;
	logic [SW-1:0]     sum;
	logic [IW-1:0]     ring_addr;
	logic [IW-1:0]     head_dec;
	logic              we;
	logic [IW-1:0]     waddr;
	logic              issue;
	logic              op_ok;
	logic              load_res;
	logic              match;
	logic [DATA_W-1:0] rd_data;

	assign accept   = in_valid && in_ready;
	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - IW'(1);
	assign match    = rd_vld_s1 && (rd_data == value_q);

	// shared ring address adder
	always_comb begin
		if (state_q == ST_SCAN) begin
			offset = scan_q;
		end else if (mode_q == MODE_PUSH_BACK) begin
			offset = count_q;
		end else begin
			offset = CW'(1);
		end
		sum = SW'(head_q) + SW'(offset);
		if (sum >= DEPTH_S) begin
			ring_addr = IW'(sum - DEPTH_S);
		end else begin
			ring_addr = IW'(sum);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = (mode_q == MODE_SEARCH) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (!rd_vld_s1 && (hit_q || scan_q == count_q)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		we       = 1'b0;
		waddr    = ring_addr;
		head_d   = head_q;
		count_d  = count_q;
		op_ok    = 1'b0;
		issue    = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EXEC: begin
				unique case (mode_q)
					MODE_PUSH_FRONT: begin
						if (!full) begin
							we      = 1'b1;
							waddr   = head_dec;
							head_d  = head_dec;
							count_d = count_q + CW'(1);
							op_ok   = 1'b1;
						end
					end
					MODE_PUSH_BACK: begin
						if (!full) begin
							we      = 1'b1;
							count_d = count_q + CW'(1);
							op_ok   = 1'b1;
						end
					end
					MODE_DROP_FRONT: begin
						if (!empty) begin
							head_d  = ring_addr;
							count_d = count_q - CW'(1);
							op_ok   = 1'b1;
						end
					end
					MODE_DROP_BACK: begin
						if (!empty) begin
							count_d = count_q - CW'(1);
							op_ok   = 1'b1;
						end
					end
					MODE_SEARCH: begin
						op_ok = 1'b1;
					end
					default: begin
						op_ok = 1'b0;
					end
				endcase
			end
			ST_SCAN: begin
				issue = (scan_q != count_q) && !hit_q && !match;
			end
			ST_DONE: begin
				load_res = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	bdq_ram #(
		.DEPTH(DEPTH),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value_q),
		.re   (issue),
		.raddr(ring_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			scan_q      <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (issue) begin
					scan_q <= scan_q + CW'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation payload and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= in_data.mode;
			value_q <= in_data.value;
		end
		if (state_q == ST_EXEC) begin
			ok_q <= op_ok;
		end
		if (load_res) begin
			res_q.ok       <= ok_q;
			res_q.found    <= hit_q;
			res_q.count    <= COUNT_W'(count_q);
			res_q.is_empty <= empty;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

endmodule

/* rtl/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque with search.
// ----------------------------------------------------------------------------
module bdq_checker #(
	parameter int DEPTH = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input bdq_pkg::bdq_out_t out_data
);
	import bdq_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one operation in flight
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |-> out_data.ok)
		else $error("hit reported on failed operation");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (DEPTH > 31) || (out_data.count <= COUNT_W'(DEPTH)))
		else $error("count above capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (DEPTH > 31) || (out_data.is_empty == (out_data.count == '0)))
		else $error("empty flag disagrees with count");

endmodule

bind bounded_deque_with_search bdq_checker #(
	.DEPTH(DEPTH)
) u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
